// File: src/bols_pkg.sv
// Shared types and constants for the bounded ordered list with search.
`default_nettype none
package bols_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	localparam logic [2:0] OP_INS_HEAD = 3'd0;
	localparam logic [2:0] OP_INS_TAIL = 3'd1;
	localparam logic [2:0] OP_REM_HEAD = 3'd2;
	localparam logic [2:0] OP_REM_TAIL = 3'd3;
	localparam logic [2:0] OP_REM_VAL  = 3'd4;
	localparam logic [2:0] OP_SEARCH   = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]               opcode;
		logic                     use_replace;
		logic signed [DATA_W-1:0] key_value;
		logic signed [DATA_W-1:0] new_value;
	} cmd_t;

	typedef struct packed {
		logic                     hit_flag;
		logic [1:0]               status_code;
		logic [CNT_W-1:0]         entry_count;
		logic signed [DATA_W-1:0] head_value;
		logic signed [DATA_W-1:0] tail_value;
	} rsp_t;

	// Per-cycle control broadcast to every cell of the chain
	typedef struct packed {
		logic              shr;
		logic              shl;
		logic              wr_en;
		logic [IDX_W-1:0]  wr_idx;
		logic [DATA_W-1:0] wr_data;
	} cell_ctl_t;

endpackage
`default_nettype wire

// File: src/bounded_ordered_list_with_search_top.sv
// Flow: a transferred command goes to S_EXEC and then S_RESULT for insert head/tail and remove
// head; remove tail, remove value and search/replace on a non-empty list pass through S_SCAN.
// The result is registered as S_RESULT is left, and no new command is taken until S_IDLE again;
// a scan pops the head each cycle and pushes kept entries back at the tail of the chain.
// Reset clears the entry count, the state and the response valid; the cells keep no reset value.
`default_nettype none
module bounded_ordered_list_with_search_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire bols_pkg::cmd_t  cmd,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output bols_pkg::rsp_t       rsp
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t                        state_q, state_d;
	bols_pkg::cmd_t                cmd_q;
	logic [bols_pkg::CNT_W-1:0]    len_q, len_d;
	logic [bols_pkg::CNT_W-1:0]    iter_q, iter_d;
	logic [bols_pkg::DATA_W-1:0]   tail_q, tail_d;
	logic                          hit_q, hit_d;
	logic [1:0]                    status_q, status_d;
	logic                          rsp_valid_q;
	bols_pkg::rsp_t                rsp_q;
	bols_pkg::cell_ctl_t           ctl;
	logic [bols_pkg::DATA_W-1:0]   head_val;
	logic                          cmd_xfer;
	logic                          rsp_load;

	bols_chain u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.head_val (head_val)
	);

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_xfer  = cmd_valid && !cmd_stall;
	assign rsp_load  = (state_q == S_RESULT) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		logic is_full;
		logic is_empty;
		logic match;
		logic drop;
		logic [bols_pkg::DATA_W-1:0] push_val;

		is_full  = (len_q == bols_pkg::CNT_W'(bols_pkg::CAPACITY));
		is_empty = (len_q == '0);
		match    = (head_val == cmd_q.key_value);
		drop     = 1'b0;
		push_val = head_val;

		state_d  = state_q;
		len_d    = len_q;
		iter_d   = iter_q;
		tail_d   = tail_q;
		hit_d    = hit_q;
		status_d = status_q;
		ctl      = '0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_xfer) begin
					hit_d    = 1'b0;
					status_d = bols_pkg::ST_OK;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_RESULT;
				iter_d  = len_q;
				unique case (cmd_q.opcode)
					bols_pkg::OP_INS_HEAD: begin
						if (is_full) begin
							status_d = bols_pkg::ST_FULL;
						end else begin
							ctl.shr     = 1'b1;
							ctl.wr_en   = 1'b1;
							ctl.wr_idx  = '0;
							ctl.wr_data = cmd_q.key_value;
							len_d       = bols_pkg::CNT_W'(len_q + 1'b1);
							if (is_empty) begin
								tail_d = cmd_q.key_value;
							end
						end
					end
					bols_pkg::OP_INS_TAIL: begin
						if (is_full) begin
							status_d = bols_pkg::ST_FULL;
						end else begin
							ctl.wr_en   = 1'b1;
							ctl.wr_idx  = len_q[bols_pkg::IDX_W-1:0];
							ctl.wr_data = cmd_q.key_value;
							len_d       = bols_pkg::CNT_W'(len_q + 1'b1);
							tail_d      = cmd_q.key_value;
						end
					end
					bols_pkg::OP_REM_HEAD: begin
						if (is_empty) begin
							status_d = bols_pkg::ST_EMPTY;
						end else begin
							ctl.shl = 1'b1;
							len_d   = bols_pkg::CNT_W'(len_q - 1'b1);
							hit_d   = 1'b1;
						end
					end
					bols_pkg::OP_REM_TAIL, bols_pkg::OP_REM_VAL: begin
						if (is_empty) begin
							status_d = bols_pkg::ST_EMPTY;
						end else begin
							state_d = S_SCAN;
						end
					end
					bols_pkg::OP_SEARCH: begin
						if (!is_empty) begin
							state_d = S_SCAN;
						end
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				// pop the head; push it back at the tail unless it goes away
				unique case (cmd_q.opcode)
					bols_pkg::OP_REM_TAIL: begin
						drop = (iter_q == bols_pkg::CNT_W'(1));
						if (drop) begin
							hit_d = 1'b1;
						end
					end
					bols_pkg::OP_REM_VAL: begin
						drop = match;
						if (match) begin
							hit_d = 1'b1;
						end
					end
					default: begin
						if (match) begin
							hit_d = 1'b1;
							if (cmd_q.use_replace) begin
								push_val = cmd_q.new_value;
							end
						end
					end
				endcase
				ctl.shl = 1'b1;
				if (drop) begin
					len_d = bols_pkg::CNT_W'(len_q - 1'b1);
				end else begin
					ctl.wr_en   = 1'b1;
					ctl.wr_idx  = bols_pkg::IDX_W'(len_q - 1'b1);
					ctl.wr_data = push_val;
					tail_d      = push_val;
				end
				iter_d = bols_pkg::CNT_W'(iter_q - 1'b1);
				if (iter_q == bols_pkg::CNT_W'(1)) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			cmd_q <= cmd;
		end
		iter_q   <= iter_d;
		tail_q   <= tail_d;
		hit_q    <= hit_d;
		status_q <= status_d;
		if (rsp_load) begin
			rsp_q.hit_flag    <= hit_q;
			rsp_q.status_code <= status_q;
			rsp_q.entry_count <= len_q;
			rsp_q.head_value  <= (len_q != '0) ? head_val : '0;
			rsp_q.tail_value  <= (len_q != '0) ? tail_q : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// File: src/bols_cell.sv
// One storage cell of the list chain: holds, shifts from a neighbor, or loads.
`default_nettype none
module bols_cell (
	input  wire logic                         clk,
	input  wire logic [bols_pkg::IDX_W-1:0]   cell_idx,
	input  wire bols_pkg::cell_ctl_t          ctl,
	input  wire logic [bols_pkg::DATA_W-1:0]  left_val,
	input  wire logic [bols_pkg::DATA_W-1:0]  right_val,
	output logic      [bols_pkg::DATA_W-1:0]  val
);

	logic [bols_pkg::DATA_W-1:0] val_q;
	logic [bols_pkg::DATA_W-1:0] val_d;

	// a direct write wins over the shift
	always_comb begin
		priority if (ctl.wr_en && (ctl.wr_idx == cell_idx)) begin
			val_d = ctl.wr_data;
		end else if (ctl.shr) begin
			val_d = left_val;
		end else if (ctl.shl) begin
			val_d = right_val;
		end else begin
			val_d = val_q;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;

endmodule
`default_nettype wire

// File: src/bols_chain.sv
// Row of list cells, head at index 0, each linked to both neighbors.
`default_nettype none
module bols_chain (
	input  wire logic                         clk,
	input  wire bols_pkg::cell_ctl_t          ctl,
	output logic      [bols_pkg::DATA_W-1:0]  head_val
);

	logic [bols_pkg::DATA_W-1:0] vals [bols_pkg::CAPACITY];

	for (genvar i = 0; i < bols_pkg::CAPACITY; i++) begin : g_cell
		logic [bols_pkg::DATA_W-1:0] left_v;
		logic [bols_pkg::DATA_W-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = vals[i-1];
		end

		if (i == bols_pkg::CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = vals[i+1];
		end

		bols_cell u_cell (
			.clk       (clk),
			.cell_idx  (bols_pkg::IDX_W'(i)),
			.ctl       (ctl),
			.left_val  (left_v),
			.right_val (right_v),
			.val       (vals[i])
		);
	end

	assign head_val = vals[0];

endmodule
`default_nettype wire
